/* hdl/ttcd_pkg.sv */
// Shared types, codes and sizes for the text terminal control decoder.
`default_nettype none

package ttcd_pkg;

    // Field widths fixed by the screen interface.
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int BYTE_W = 8;

    // Default screen geometry.
    localparam int DEF_WRAP_COLUMN = 79;
    localparam int DEF_LAST_ROW    = 24;
    localparam int DEF_TAB_STOP    = 8;

    // Depth of the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Reset colour attribute.
    localparam logic [BYTE_W-1:0] RESET_COLOUR = 8'h07;

    // Special bytes of the character stream.
    localparam logic [BYTE_W-1:0] CHR_SEQ = 8'd1;
    localparam logic [BYTE_W-1:0] CHR_TAB = 8'd9;
    localparam logic [BYTE_W-1:0] CHR_CR  = 8'd13;

    // Control sequence command codes.
    localparam logic [BYTE_W-1:0] CMD_CLEAR    = 8'd1;
    localparam logic [BYTE_W-1:0] CMD_COLOUR   = 8'd2;
    localparam logic [BYTE_W-1:0] CMD_SCROLL   = 8'd3;
    localparam logic [BYTE_W-1:0] CMD_UP       = 8'd4;
    localparam logic [BYTE_W-1:0] CMD_DOWN     = 8'd5;
    localparam logic [BYTE_W-1:0] CMD_LEFT     = 8'd6;
    localparam logic [BYTE_W-1:0] CMD_RIGHT    = 8'd7;
    localparam logic [BYTE_W-1:0] CMD_GOTO     = 8'd11;
    localparam logic [BYTE_W-1:0] CMD_HOME_COL = 8'd12;
    localparam logic [BYTE_W-1:0] CMD_HOME_ROW = 8'd13;
    localparam logic [BYTE_W-1:0] CMD_HOME     = 8'd14;
    localparam logic [BYTE_W-1:0] CMD_END_COL  = 8'd15;
    localparam logic [BYTE_W-1:0] CMD_END_ROW  = 8'd16;
    localparam logic [BYTE_W-1:0] CMD_END      = 8'd17;

    // Sequence length codes.
    localparam logic [1:0] SEQ_LEN_ONE   = 2'd1;
    localparam logic [1:0] SEQ_LEN_TWO   = 2'd2;
    localparam logic [1:0] SEQ_LEN_THREE = 2'd3;

    // Screen action reported with each result.
    typedef enum logic [1:0] {
        ACT_CURSOR = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_SCROLL = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    // Operation class decided by the front part.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_TAB,
        OP_CR,
        OP_PUT,
        OP_CMD
    } op_kind_t;

    // One queued operation.
    typedef struct packed {
        op_kind_t          kind;
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] arg_a;
        logic [BYTE_W-1:0] arg_b;
    } op_t;

    // Queue handshake seen by the back part.
    typedef struct packed {
        logic valid;
        op_t  op;
    } queue_head_t;

    // One result transaction.
    typedef struct packed {
        action_t           action;
        logic [COL_W-1:0]  cell_column;
        logic [ROW_W-1:0]  cell_row;
        logic [BYTE_W-1:0] char_code;
        logic [BYTE_W-1:0] attribute;
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

/* hdl/text_terminal_control_decoder.sv */
// Top level of the text terminal control decoder.
//
//   Channel   Direction  Handshake                  Payload
//   byte      in         byte_valid / byte_stall    byte_in
//   result    out        result_valid / result_stall action, cell_column, cell_row,
//                                                   char_code, attribute, cursor_column,
//                                                   cursor_row, last
//
// A byte gives one result, or two when a cell write runs past the last row
// and is followed by a scroll; the single result register of the back part sends them in turn.
// When the queue is empty, an accepted byte is stored in a queue entry and then in the result register.
// Reset (rst_n low) clears the parser, the queue, the cursor and sets colour 0x07.
// A stalled result holds; the two-entry queue keeps bytes flowing until it fills.
`default_nettype none

module text_terminal_control_decoder #(
    parameter int WRAP_COLUMN = ttcd_pkg::DEF_WRAP_COLUMN,
    parameter int LAST_ROW    = ttcd_pkg::DEF_LAST_ROW,
    parameter int TAB_STOP    = ttcd_pkg::DEF_TAB_STOP
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          byte_valid,
    output logic                               byte_stall,
    input  wire logic [ttcd_pkg::BYTE_W-1:0]   byte_in,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic [1:0]                         action,
    output logic [ttcd_pkg::COL_W-1:0]         cell_column,
    output logic [ttcd_pkg::ROW_W-1:0]         cell_row,
    output logic [ttcd_pkg::BYTE_W-1:0]        char_code,
    output logic [ttcd_pkg::BYTE_W-1:0]        attribute,
    output logic [ttcd_pkg::COL_W-1:0]         cursor_column,
    output logic [ttcd_pkg::ROW_W-1:0]         cursor_row,
    output logic                               last
);

    logic                   push;
    ttcd_pkg::op_t          push_op;
    logic                   queue_full;
    logic                   pop;
    ttcd_pkg::queue_head_t  head;
    ttcd_pkg::result_t      result;

    // Parser and classifier.
    ttcd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_in    (byte_in),
        .queue_full (queue_full),
        .byte_stall (byte_stall),
        .push       (push),
        .push_op    (push_op)
    );

    // Operation queue.
    ttcd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .full    (queue_full),
        .head    (head)
    );

    // Execution and results.
    ttcd_back #(
        .WRAP_COLUMN (WRAP_COLUMN),
        .LAST_ROW    (LAST_ROW),
        .TAB_STOP    (TAB_STOP)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .result_stall (result_stall),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

    assign action        = result.action;
    assign cell_column   = result.cell_column;
    assign cell_row      = result.cell_row;
    assign char_code     = result.char_code;
    assign attribute     = result.attribute;
    assign cursor_column = result.cursor_column;
    assign cursor_row    = result.cursor_row;
    assign last          = result.last;

endmodule

`default_nettype wire

/* hdl/ttcd_front.sv */
// Front part: control-sequence parser that classifies each byte into an operation.
`default_nettype none

module ttcd_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          byte_valid,
    input  wire logic [ttcd_pkg::BYTE_W-1:0]   byte_in,
    input  wire logic                          queue_full,
    output logic                               byte_stall,
    output logic                               push,
    output ttcd_pkg::op_t                      push_op
);

    logic                        in_seq_reg, in_seq_next;
    logic [1:0]                  arg_cnt_reg, arg_cnt_next;
    logic [1:0]                  seq_len_reg, seq_len_next;
    logic [ttcd_pkg::BYTE_W-1:0] seq_b0_reg, seq_b0_next;
    logic [ttcd_pkg::BYTE_W-1:0] seq_b1_reg, seq_b1_next;
    logic [1:0]                  len_eff;
    logic [2:0]                  arg_inc;

    // The queue has room for exactly one operation per accepted byte.
    assign byte_stall = queue_full;
    assign push       = byte_valid && !queue_full;

    // The first byte of a sequence fixes its length.
    always_comb
    begin
        len_eff = seq_len_reg;
        if (arg_cnt_reg == 2'd0) begin
            if (byte_in == ttcd_pkg::CMD_COLOUR)
                len_eff = ttcd_pkg::SEQ_LEN_TWO;
            else if (byte_in == ttcd_pkg::CMD_GOTO)
                len_eff = ttcd_pkg::SEQ_LEN_THREE;
        end
        arg_inc = {1'b0, arg_cnt_reg} + 3'd1;
    end

    // Parser update and operation classification.
    always_comb
    begin
        in_seq_next   = in_seq_reg;
        arg_cnt_next  = arg_cnt_reg;
        seq_len_next  = seq_len_reg;
        seq_b0_next   = seq_b0_reg;
        seq_b1_next   = seq_b1_reg;
        push_op.kind  = ttcd_pkg::OP_NOP;
        push_op.code  = byte_in;
        push_op.arg_a = seq_b1_reg;
        push_op.arg_b = byte_in;
        if (in_seq_reg) begin
            seq_len_next = len_eff;
            if (arg_cnt_reg == 2'd0)
                seq_b0_next = byte_in;
            if (arg_cnt_reg == 2'd1)
                seq_b1_next = byte_in;
            if (arg_inc >= {1'b0, len_eff}) begin
                // Sequence complete: hand the command over.
                in_seq_next  = 1'b0;
                arg_cnt_next = 2'd0;
                push_op.kind = ttcd_pkg::OP_CMD;
                if (arg_cnt_reg != 2'd0)
                    push_op.code = seq_b0_reg;
                if (arg_cnt_reg == 2'd1)
                    push_op.arg_a = byte_in;
            end else begin
                arg_cnt_next = arg_inc[1:0];
            end
        end else if (byte_in == ttcd_pkg::CHR_TAB) begin
            push_op.kind = ttcd_pkg::OP_TAB;
        end else if (byte_in == ttcd_pkg::CHR_SEQ) begin
            in_seq_next  = 1'b1;
            arg_cnt_next = 2'd0;
            seq_len_next = ttcd_pkg::SEQ_LEN_ONE;
        end else if (byte_in == ttcd_pkg::CHR_CR) begin
            push_op.kind = ttcd_pkg::OP_CR;
        end else begin
            push_op.kind = ttcd_pkg::OP_PUT;
        end
    end

    // Parser control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_seq_reg  <= 1'b0;
            arg_cnt_reg <= 2'd0;
            seq_len_reg <= ttcd_pkg::SEQ_LEN_ONE;
        end else if (push) begin
            in_seq_reg  <= in_seq_next;
            arg_cnt_reg <= arg_cnt_next;
            seq_len_reg <= seq_len_next;
        end
    end

    // Sequence bytes are written before they are read and need no reset.
    always_ff @(posedge clk)
    begin
        if (push) begin
            seq_b0_reg <= seq_b0_next;
            seq_b1_reg <= seq_b1_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/ttcd_queue.sv */
// Short operation queue between the front and the back part.
`default_nettype none

module ttcd_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire ttcd_pkg::op_t         push_op,
    input  wire logic                  pop,
    output logic                       full,
    output ttcd_pkg::queue_head_t      head
);

    ttcd_pkg::op_t                 entry_reg [ttcd_pkg::QUEUE_DEPTH];
    logic [ttcd_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ttcd_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ttcd_pkg::QCNT_W-1:0]   count_reg, count_next;

    localparam logic [ttcd_pkg::QPTR_W-1:0] PTR_MAX =
        ttcd_pkg::QPTR_W'(ttcd_pkg::QUEUE_DEPTH - 1);
    localparam logic [ttcd_pkg::QCNT_W-1:0] CNT_FULL =
        ttcd_pkg::QCNT_W'(ttcd_pkg::QUEUE_DEPTH);

    assign full       = (count_reg == CNT_FULL);
    assign head.valid = (count_reg != '0);
    assign head.op    = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

endmodule

`default_nettype wire

/* hdl/ttcd_back.sv */
// Back part: cursor and colour state, operation execution and the result register.
`default_nettype none

module ttcd_back #(
    parameter int WRAP_COLUMN = ttcd_pkg::DEF_WRAP_COLUMN,
    parameter int LAST_ROW    = ttcd_pkg::DEF_LAST_ROW,
    parameter int TAB_STOP    = ttcd_pkg::DEF_TAB_STOP
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ttcd_pkg::queue_head_t  head,
    input  wire logic                   result_stall,
    output logic                        pop,
    output logic                        result_valid,
    output ttcd_pkg::result_t           result
);

    localparam int COL_W = ttcd_pkg::COL_W;
    localparam int ROW_W = ttcd_pkg::ROW_W;
    localparam int TAB_W = COL_W + 2;
    localparam int NSTOP = (1 << COL_W) / TAB_STOP + 1;

    localparam logic [COL_W-1:0] WRAP_C   = COL_W'(WRAP_COLUMN);
    localparam logic [COL_W-1:0] WRAP_M1  = COL_W'(WRAP_COLUMN - 1);
    localparam logic [COL_W:0]   WRAP_X   = (COL_W + 1)'(WRAP_COLUMN);
    localparam logic [TAB_W-1:0] WRAP_T   = TAB_W'(WRAP_COLUMN);
    localparam logic [ROW_W-1:0] LAST_C   = ROW_W'(LAST_ROW);
    localparam logic [ttcd_pkg::BYTE_W-1:0] WRAP_B = ttcd_pkg::BYTE_W'(WRAP_COLUMN);
    localparam logic [ttcd_pkg::BYTE_W-1:0] LAST_B = ttcd_pkg::BYTE_W'(LAST_ROW);

    logic [COL_W-1:0]            col_reg, col_next;
    logic [ROW_W-1:0]            row_reg, row_next;
    logic [ttcd_pkg::BYTE_W-1:0] colour_reg, colour_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        pend_reg, pend_next;
    ttcd_pkg::result_t           out_reg, out_next;

    logic [COL_W:0]              col_inc;
    logic                        row_last;
    logic [TAB_W-1:0]            tab_next;
    logic                        out_free;
    logic                        two;
    ttcd_pkg::action_t           act;
    logic [COL_W-1:0]            cell_col;
    logic [ROW_W-1:0]            cell_row;
    logic [ttcd_pkg::BYTE_W-1:0] cell_char;

    assign col_inc  = {1'b0, col_reg} + 1'b1;
    assign row_last = (row_reg >= LAST_C);
    assign out_free = !out_valid_reg || !result_stall;
    assign pop      = head.valid && out_free && !pend_reg;

    // Next tab stop: the smallest multiple of the stop above the column.
    always_comb
    begin
        tab_next = '0;
        for (int k = NSTOP; k >= 1; k--) begin
            if ((k * TAB_STOP) > int'(col_reg))
                tab_next = TAB_W'(k * TAB_STOP);
        end
    end

    // Execute the operation at the head of the queue.
    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        colour_next = colour_reg;
        act         = ttcd_pkg::ACT_CURSOR;
        cell_col    = '0;
        cell_row    = '0;
        cell_char   = '0;
        two         = 1'b0;
        unique case (head.op.kind)
            ttcd_pkg::OP_PUT:
            begin
                act       = ttcd_pkg::ACT_WRITE;
                cell_col  = col_reg;
                cell_row  = row_reg;
                cell_char = head.op.code;
                if (col_inc >= WRAP_X) begin
                    col_next = '0;
                    if (row_last) begin
                        // Wrap past the last row: write, then scroll.
                        row_next = LAST_C;
                        two      = 1'b1;
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end else begin
                    col_next = col_inc[COL_W-1:0];
                end
            end
            ttcd_pkg::OP_TAB:
            begin
                if (tab_next > WRAP_T) begin
                    col_next = '0;
                    if (row_last) begin
                        act      = ttcd_pkg::ACT_SCROLL;
                        row_next = LAST_C;
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end else begin
                    col_next = tab_next[COL_W-1:0];
                end
            end
            ttcd_pkg::OP_CR:
            begin
                col_next = '0;
                if (row_last) begin
                    act      = ttcd_pkg::ACT_SCROLL;
                    row_next = LAST_C;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end
            ttcd_pkg::OP_CMD:
            begin
                unique case (head.op.code)
                    ttcd_pkg::CMD_CLEAR:
                    begin
                        act      = ttcd_pkg::ACT_CLEAR;
                        col_next = '0;
                        row_next = '0;
                    end
                    ttcd_pkg::CMD_COLOUR:
                        colour_next = head.op.arg_a;
                    ttcd_pkg::CMD_SCROLL:
                        act = ttcd_pkg::ACT_SCROLL;
                    ttcd_pkg::CMD_UP:
                    begin
                        if (row_reg != '0)
                            row_next = row_reg - 1'b1;
                    end
                    ttcd_pkg::CMD_DOWN:
                    begin
                        if (row_last) begin
                            act      = ttcd_pkg::ACT_SCROLL;
                            row_next = LAST_C;
                        end else begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    ttcd_pkg::CMD_LEFT:
                    begin
                        // At the left edge go to the end of the row above, unless at home.
                        if (col_reg == '0) begin
                            if (row_reg != '0) begin
                                col_next = WRAP_M1;
                                row_next = row_reg - 1'b1;
                            end
                        end else begin
                            col_next = col_reg - 1'b1;
                        end
                    end
                    ttcd_pkg::CMD_RIGHT:
                    begin
                        if (col_inc >= WRAP_X) begin
                            col_next = '0;
                            if (row_last) begin
                                act      = ttcd_pkg::ACT_SCROLL;
                                row_next = LAST_C;
                            end else begin
                                row_next = row_reg + 1'b1;
                            end
                        end else begin
                            col_next = col_inc[COL_W-1:0];
                        end
                    end
                    ttcd_pkg::CMD_GOTO:
                    begin
                        // Out-of-range coordinates saturate at the screen edge.
                        col_next = (head.op.arg_a > WRAP_B) ? WRAP_C
                                                            : head.op.arg_a[COL_W-1:0];
                        row_next = (head.op.arg_b > LAST_B) ? LAST_C
                                                            : head.op.arg_b[ROW_W-1:0];
                    end
                    ttcd_pkg::CMD_HOME_COL:
                        col_next = '0;
                    ttcd_pkg::CMD_HOME_ROW:
                        row_next = '0;
                    ttcd_pkg::CMD_HOME:
                    begin
                        col_next = '0;
                        row_next = '0;
                    end
                    ttcd_pkg::CMD_END_COL:
                        col_next = WRAP_C;
                    ttcd_pkg::CMD_END_ROW:
                        row_next = LAST_C;
                    ttcd_pkg::CMD_END:
                    begin
                        col_next = WRAP_C;
                        row_next = LAST_C;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // Result register: the first result of an operation, then a pending scroll if any.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        if (out_free) begin
            if (pend_reg) begin
                out_valid_next        = 1'b1;
                pend_next             = 1'b0;
                out_next.action       = ttcd_pkg::ACT_SCROLL;
                out_next.cell_column  = '0;
                out_next.cell_row     = '0;
                out_next.char_code    = '0;
                out_next.attribute    = colour_reg;
                out_next.cursor_column = col_reg;
                out_next.cursor_row   = row_reg;
                out_next.last         = 1'b1;
            end else if (pop) begin
                out_valid_next        = 1'b1;
                pend_next             = two;
                out_next.action       = act;
                out_next.cell_column  = cell_col;
                out_next.cell_row     = cell_row;
                out_next.char_code    = cell_char;
                out_next.attribute    = colour_next;
                out_next.cursor_column = col_next;
                out_next.cursor_row   = row_next;
                out_next.last         = !two;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    // Cursor, colour and output control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_reg       <= '0;
            row_reg       <= '0;
            colour_reg    <= ttcd_pkg::RESET_COLOUR;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            if (pop) begin
                col_reg    <= col_next;
                row_reg    <= row_next;
                colour_reg <= colour_next;
            end
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

/* hdl/ttcd_checker.sv */
// Port-level checker for the text terminal control decoder and its bind.
`default_nettype none

module ttcd_checker #(
    parameter int WRAP_COLUMN = ttcd_pkg::DEF_WRAP_COLUMN,
    parameter int LAST_ROW    = ttcd_pkg::DEF_LAST_ROW
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          result_valid,
    input  wire logic                          result_stall,
    input  wire logic [1:0]                    action,
    input  wire logic [ttcd_pkg::COL_W-1:0]    cell_column,
    input  wire logic [ttcd_pkg::ROW_W-1:0]    cell_row,
    input  wire logic [ttcd_pkg::BYTE_W-1:0]   char_code,
    input  wire logic [ttcd_pkg::BYTE_W-1:0]   attribute,
    input  wire logic [ttcd_pkg::COL_W-1:0]    cursor_column,
    input  wire logic [ttcd_pkg::ROW_W-1:0]    cursor_row,
    input  wire logic                          last
);

    localparam logic [ttcd_pkg::COL_W-1:0] WRAP_C = ttcd_pkg::COL_W'(WRAP_COLUMN);
    localparam logic [ttcd_pkg::ROW_W-1:0] LAST_C = ttcd_pkg::ROW_W'(LAST_ROW);

    // A stalled result transaction holds.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid &&
            $stable({action, cell_column, cell_row, char_code, attribute,
                     cursor_column, cursor_row, last}))
        else $error("stalled result changed");

    // A result that is not the last of its byte is followed at once by the scroll.
    a_scroll_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !last |=>
            result_valid && last && (action == 2'(ttcd_pkg::ACT_SCROLL)))
        else $error("second result of a byte is not a scroll");

    // Only a cell write can be followed by another result of the same byte.
    a_first_is_write: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> action == 2'(ttcd_pkg::ACT_WRITE))
        else $error("non-final result is not a cell write");

    // The cursor always stays on the screen.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (cursor_column <= WRAP_C) && (cursor_row <= LAST_C))
        else $error("cursor off the screen");

    // Written cells lie on the screen.
    a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (action == 2'(ttcd_pkg::ACT_WRITE)) |->
            (cell_column <= WRAP_C) && (cell_row <= LAST_C))
        else $error("written cell off the screen");

endmodule

bind text_terminal_control_decoder ttcd_checker #(
    .WRAP_COLUMN (WRAP_COLUMN),
    .LAST_ROW    (LAST_ROW)
) u_ttcd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .action        (action),
    .cell_column   (cell_column),
    .cell_row      (cell_row),
    .char_code     (char_code),
    .attribute     (attribute),
    .cursor_column (cursor_column),
    .cursor_row    (cursor_row),
    .last          (last)
);

`default_nettype wire
